[rtl/arpd_pkg.sv]
// Package for the remote pulse decoder: frame constants, codes and the
// structs passed between the pulse tracker and the result decode.
// No dependencies.
`default_nettype none

package arpd_pkg;

  // Frame geometry
  localparam int DataBits = 12;
  localparam logic [5:0] FrameLen    = 6'd50;
  localparam logic [5:0] LastIdx     = 6'd49;
  localparam logic [5:0] IndexMax    = 6'd63;
  localparam logic [5:0] FirstGroup  = 6'd4;
  localparam logic [5:0] QuartetLast = 6'd48;
  localparam logic [5:0] ExtremeFrom = 6'd2;

  // Register reset values
  localparam logic [7:0] ThresholdReset = 8'd24;
  localparam logic [7:0] UnitReset      = 8'd25;
  localparam logic [7:0] ExtremeStart   = 8'd22;

  // Register indexes
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_UNIT      = 1'b1
  } reg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LENGTH  = 2'd1,
    ST_PATTERN = 2'd2,
    ST_FIXED   = 2'd3
  } status_t;

  // Group patterns, first pulse in bit 3 (1 = long)
  localparam logic [3:0] Q_SLSL = 4'h5;
  localparam logic [3:0] Q_SLLS = 4'h6;
  localparam logic [3:0] Q_SLSS = 4'h4;
  localparam logic [3:0] Q_LLSL = 4'hD;

  // One-of-five button codes of the five-bit-house variant
  localparam logic [4:0] BTN_1 = 5'h1E;
  localparam logic [4:0] BTN_2 = 5'h1D;
  localparam logic [4:0] BTN_3 = 5'h1B;
  localparam logic [4:0] BTN_4 = 5'h17;
  localparam logic [4:0] BTN_5 = 5'h0F;

  localparam logic [6:0] HouseBase = 7'h41;

  // Timing window of the variant, in microseconds
  localparam logic [15:0] LoMin  = 16'd125;
  localparam logic [15:0] LoMax  = 16'd300;
  localparam logic [15:0] HiMin  = 16'd775;
  localparam logic [15:0] HiMax  = 16'd925;
  localparam logic [15:0] LoExA  = 16'd225;
  localparam logic [15:0] LoExB  = 16'd250;
  localparam logic [15:0] HiExA  = 16'd900;
  localparam logic [15:0] HiExB  = 16'd925;

  // Frame summary captured at frame end
  typedef struct packed {
    logic [DataBits-1:0] word;
    logic [7:0]          shortest;
    logic [7:0]          longest;
    logic                len_bad;
    logic                pat_err;
    logic                group;
  } frame_sum_t;

  // Decoded result
  typedef struct packed {
    status_t             status;
    logic                variant;
    logic [6:0]          house;
    logic [4:0]          unit;
    logic                switch_on;
    logic                group;
    logic [DataBits-1:0] word;
  } result_t;

endpackage

`default_nettype wire

[rtl/arpd_in_if.sv]
// Pulse request channel of the remote pulse decoder.
// Carries one measured pulse with its frame markers; no dependencies.
`default_nettype none

interface arpd_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] pulse_len;
  logic       frame_start;
  logic       frame_end;

  modport source (output valid, output pulse_len, output frame_start,
                  output frame_end, input ready);
  modport sink   (input valid, input pulse_len, input frame_start,
                  input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/arpd_out_if.sv]
// Result request channel of the remote pulse decoder.
// Carries one decoded frame; no dependencies.
`default_nettype none

interface arpd_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        long_house_variant;
  logic [6:0]  house_letter;
  logic [4:0]  unit_number;
  logic        switch_on;
  logic        group_flag;
  logic [11:0] raw_word;

  modport source (output valid, output status, output long_house_variant,
                  output house_letter, output unit_number, output switch_on,
                  output group_flag, output raw_word, input ready);
  modport sink   (input valid, input status, input long_house_variant,
                  input house_letter, input unit_number, input switch_on,
                  input group_flag, input raw_word, output ready);
endinterface

`default_nettype wire

[rtl/arpd_result_calc.sv]
// Result decode of the remote pulse decoder: timing class, house and unit
// decode and status from a captured frame summary. Depends on arpd_pkg.
`default_nettype none

module arpd_result_calc import arpd_pkg::*; (
  input  frame_sum_t sum,
  input  logic [7:0] unit_us,
  output result_t    res
);

  logic [15:0] lo;
  logic [15:0] hi;
  logic        timing_ok;
  logic        excluded;
  logic [4:0]  btn;
  logic [4:0]  btn_unit;
  logic        variant;

  // Scale extremes to microseconds
  assign lo = 16'(sum.shortest) * 16'(unit_us);
  assign hi = 16'(sum.longest) * 16'(unit_us);

  // Classify timing
  assign excluded  = (lo == LoExA || lo == LoExB) && (hi == HiExA || hi == HiExB);
  assign timing_ok = !excluded && lo >= LoMin && lo <= LoMax && hi >= HiMin && hi <= HiMax;

  // Decode one-of-five button
  assign btn = sum.word[9:5];
  always_comb begin
    unique case (btn)
      BTN_1:   btn_unit = 5'd1;
      BTN_2:   btn_unit = 5'd2;
      BTN_3:   btn_unit = 5'd3;
      BTN_4:   btn_unit = 5'd4;
      BTN_5:   btn_unit = 5'd5;
      default: btn_unit = 5'd0;
    endcase
  end

  assign variant = timing_ok && (btn_unit != 5'd0);

  // Assemble result; status by priority
  always_comb begin
    res.variant   = variant;
    res.switch_on = sum.word[11];
    res.group     = sum.group;
    res.word      = sum.word;
    if (variant) begin
      res.house = HouseBase + {2'b00, ~sum.word[4:0]};
      res.unit  = btn_unit;
    end else begin
      res.house = HouseBase + {3'b000, sum.word[3:0]};
      res.unit  = {1'b0, sum.word[7:4]} + 5'd1;
    end
    priority if (sum.len_bad) begin
      res.status = ST_LENGTH;
    end else if (sum.pat_err) begin
      res.status = ST_PATTERN;
    end else if (!variant && sum.word[10:9] != 2'b11) begin
      res.status = ST_FIXED;
    end else begin
      res.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

[rtl/arc_remote_pulse_decoder_unit.sv]
// Remote pulse decoder, top level. Depends on arpd_pkg, arpd_in_if,
// arpd_out_if and arpd_result_calc.
//
// Usage:
//   in_ch  - one pulse length per request, with frame_start / frame_end marks.
//   out_ch - one decoded frame per request, sent for each frame_end pulse.
//   APB port - register 0 (addr 0) pulse threshold, register 1 (addr 4)
//   sample unit in microseconds; pready is always high.
// Throughput: one pulse per cycle while in_ch.ready is high. Frame state
//   (index, group bits, word, extremes, error flags) updates on accept.
// Result path: a frame_end pulse is captured into a summary register at its
//   accept edge; the timing multiply and decode then run, and the result is
//   loaded into the output register once that register is empty or being
//   taken, raising out_ch.valid.
// Stall: while the output register holds an untaken result the summary
//   register may still fill; in_ch.ready drops only when both are full.
// Reset: synchronous, active low; registers return to threshold 24 and
//   unit 25, frame state clears and both channels are empty.
`default_nettype none

module arc_remote_pulse_decoder_unit import arpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  arpd_in_if.sink          in_ch,
  arpd_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers
  logic [7:0] thr_r;
  logic [7:0] unit_us_r;
  reg_idx_t   reg_sel;

  // Frame state
  logic [5:0]          idx_r;
  logic [3:0]          quartet_r;
  logic [DataBits-1:0] word_r;
  logic [7:0]          min_r;
  logic [7:0]          max_r;
  logic                pat_r;
  logic                grp_r;
  logic                len_r;

  logic [5:0]          idx;
  logic [3:0]          quartet;
  logic [DataBits-1:0] word;
  logic [7:0]          mn;
  logic [7:0]          mx;
  logic                pat;
  logic                grp;
  logic                len;

  logic [5:0]          idx_nxt;
  logic [3:0]          quartet_nxt;
  logic [DataBits-1:0] word_nxt;
  logic [7:0]          min_nxt;
  logic [7:0]          max_nxt;
  logic                pat_nxt;
  logic                grp_nxt;
  logic                len_nxt;
  logic                new_bit;
  logic                in_data;

  // Pipeline
  frame_sum_t sum_r;
  frame_sum_t sum_nxt;
  logic       sum_v_r;
  result_t    res;
  result_t    out_r;
  logic       out_v_r;
  logic       acc;
  logic       adv;
  logic [7:0] p;

  // APB register access
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  always_comb begin
    unique case (reg_sel)
      REG_THRESHOLD: prdata = {24'd0, thr_r};
      REG_UNIT:      prdata = {24'd0, unit_us_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= ThresholdReset;
      unit_us_r <= UnitReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_THRESHOLD: thr_r     <= pwdata[7:0];
        REG_UNIT:      unit_us_r <= pwdata[7:0];
        default:       thr_r     <= thr_r;
      endcase
    end
  end

  // Handshake
  assign p           = in_ch.pulse_len;
  assign adv         = sum_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !sum_v_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // Start from cleared state on frame_start
  always_comb begin
    if (in_ch.frame_start) begin
      idx = '0; quartet = '0; word = '0; mn = ExtremeStart; mx = ExtremeStart;
      pat = 1'b0; grp = 1'b0; len = 1'b0;
    end else begin
      idx = idx_r; quartet = quartet_r; word = word_r; mn = min_r; mx = max_r;
      pat = pat_r; grp = grp_r; len = len_r;
    end
  end

  // Class pulse, finish groups, track extremes
  assign in_data = (idx >= 6'd1) && (idx <= QuartetLast);
  always_comb begin
    idx_nxt     = (idx < IndexMax) ? idx + 6'd1 : idx;
    len_nxt     = len || (idx >= FrameLen);
    quartet_nxt = quartet;
    word_nxt    = word;
    pat_nxt     = pat;
    grp_nxt     = grp;
    min_nxt     = mn;
    max_nxt     = mx;
    new_bit     = 1'b0;
    if (in_data) begin
      if (p == thr_r) begin
        pat_nxt = 1'b1;
      end
      quartet_nxt = {quartet[2:0], p > thr_r};
      if (idx[1:0] == 2'b00) begin
        unique case (quartet_nxt)
          Q_SLSL: new_bit = 1'b0;
          Q_SLLS: new_bit = 1'b1;
          Q_SLSS: grp_nxt = 1'b1;
          default: begin
            if (!(idx == FirstGroup && quartet_nxt == Q_LLSL)) begin
              pat_nxt = 1'b1;
            end
          end
        endcase
        word_nxt = {new_bit, word[DataBits-1:1]};
      end
    end
    if (idx >= ExtremeFrom) begin
      if (p < mn) begin
        min_nxt = p;
      end else if (p > mx) begin
        max_nxt = p;
      end
    end
  end

  // Frame summary for the decode stage
  always_comb begin
    sum_nxt.word     = word_nxt;
    sum_nxt.shortest = min_nxt;
    sum_nxt.longest  = max_nxt;
    sum_nxt.len_bad  = len_nxt || (idx != LastIdx);
    sum_nxt.pat_err  = pat_nxt;
    sum_nxt.group    = grp_nxt;
  end

  // Advance frame state; clear after frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; quartet_r <= '0; word_r <= '0;
      min_r <= ExtremeStart; max_r <= ExtremeStart;
      pat_r <= 1'b0; grp_r <= 1'b0; len_r <= 1'b0;
    end else if (acc) begin
      if (in_ch.frame_end) begin
        idx_r <= '0; quartet_r <= '0; word_r <= '0;
        min_r <= ExtremeStart; max_r <= ExtremeStart;
        pat_r <= 1'b0; grp_r <= 1'b0; len_r <= 1'b0;
      end else begin
        idx_r <= idx_nxt; quartet_r <= quartet_nxt; word_r <= word_nxt;
        min_r <= min_nxt; max_r <= max_nxt;
        pat_r <= pat_nxt; grp_r <= grp_nxt; len_r <= len_nxt;
      end
    end
  end

  // Summary register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else if (acc && in_ch.frame_end) begin
      sum_v_r <= 1'b1;
    end else if (adv) begin
      sum_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.frame_end) begin
      sum_r <= sum_nxt;
    end
  end

  arpd_result_calc u_calc (
    .sum     (sum_r),
    .unit_us (unit_us_r),
    .res     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.status             = out_r.status;
  assign out_ch.long_house_variant = out_r.variant;
  assign out_ch.house_letter       = out_r.house;
  assign out_ch.unit_number        = out_r.unit;
  assign out_ch.switch_on          = out_r.switch_on;
  assign out_ch.group_flag         = out_r.group;
  assign out_ch.raw_word           = out_r.word;

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !sum_v_r |-> in_ch.ready)
    else $error("input stalled with empty summary register");

  a_end_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.frame_end) |=> sum_v_r)
    else $error("frame end not captured");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.frame_end) |=> (idx_r == '0 && !pat_r && !len_r))
    else $error("frame state not cleared after frame end");

  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(sum_v_r))
    else $error("result without captured frame");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!acc && !in_ch.frame_start) |=> $stable(idx_r))
    else $error("pulse index moved without a request");

endmodule

`default_nettype wire
